>>> rtl/rfcd_pkg.sv
package rfcd_pkg;

    localparam int TAG_BYTES_DEF = 12;

    localparam logic [7:0] MARK_START = 8'd2;
    localparam logic [7:0] MARK_END   = 8'd3;

    typedef enum logic [1:0] {
        KIND_DATA,
        KIND_START,
        KIND_END,
        KIND_CLEAR
    } item_kind_t;

    // controller -> datapath
    typedef struct packed {
        logic push;        // store data byte at write position
        logic wp_clr;      // frame end: rewind write position
        logic at_clr;      // forget accepted tag
        logic flags_init;  // start a compare pass
        logic cnt_clr;
        logic cnt_inc;
        logic rd_en;       // read all three stores at the scan counter
        logic cmp_en;      // compare read data, copy frame into previous
        logic emit_ld;     // load a tag byte into the output register
        logic nodet_ld;    // load the not-detected result
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        item_kind_t kind;
        logic       rd_last;
        logic       confirmed;
        logic       is_new;
        logic       out_free;
    } dp_stat_t;

endpackage

>>> rtl/rfcd_dp.sv
module rfcd_dp
    import rfcd_pkg::*;
#(
    parameter int TAG_BYTES = TAG_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [7:0]  s_tdata,
    input  logic        s_tuser,
    input  logic        m_tready,
    output logic        m_tvalid,
    output logic [15:0] m_tdata,
    output logic        m_tuser,
    output logic        m_tlast,
    input  dp_cmd_t     cmd,
    output dp_stat_t    stat
);

    localparam int IDX_W = (TAG_BYTES > 1) ? $clog2(TAG_BYTES) : 1;
    localparam int CNT_W = $clog2(TAG_BYTES + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TAG_BYTES - 1);
    localparam logic [CNT_W-1:0] FULL_POS = CNT_W'(TAG_BYTES);

    logic [7:0] fb_mem [TAG_BYTES];
    logic [7:0] pf_mem [TAG_BYTES];
    logic [7:0] at_mem [TAG_BYTES];
    logic [TAG_BYTES-1:0] fb_vld_reg, pf_vld_reg, at_vld_reg;

    logic [CNT_W-1:0] wp_reg;
    logic [IDX_W-1:0] cnt_reg;
    logic [IDX_W-1:0] addr_q_reg;
    logic [7:0]       fb_rd_reg, pf_rd_reg, at_rd_reg;
    logic             confirmed_reg, is_new_reg;

    logic             out_valid_reg;
    logic [7:0]       out_byte_reg;
    logic [3:0]       out_idx_reg;
    logic             out_det_reg, out_last_reg;

    logic             wp_open;
    logic             out_free;
    logic [7:0]       idx_wide;
    item_kind_t       kind;

    assign wp_open  = (wp_reg != FULL_POS);
    assign out_free = !out_valid_reg || m_tready;
    assign idx_wide = 8'(addr_q_reg);

    always_comb begin
        if (s_tuser) begin
            kind = KIND_CLEAR;
        end else begin
            unique case (s_tdata)
                MARK_START: kind = KIND_START;
                MARK_END:   kind = KIND_END;
                default:    kind = KIND_DATA;
            endcase
        end
    end

    // store arrays
    always_ff @(posedge aclk) begin
        if (cmd.push && wp_open) begin
            fb_mem[wp_reg[IDX_W-1:0]] <= s_tdata;
        end
        if (cmd.cmp_en) begin
            pf_mem[addr_q_reg] <= fb_rd_reg;
        end
        if (cmd.emit_ld) begin
            at_mem[addr_q_reg] <= fb_rd_reg;
        end
        // entries never written read as zero
        if (cmd.rd_en) begin
            fb_rd_reg  <= fb_vld_reg[cnt_reg] ? fb_mem[cnt_reg] : 8'd0;
            pf_rd_reg  <= pf_vld_reg[cnt_reg] ? pf_mem[cnt_reg] : 8'd0;
            at_rd_reg  <= at_vld_reg[cnt_reg] ? at_mem[cnt_reg] : 8'd0;
            addr_q_reg <= cnt_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fb_vld_reg    <= '0;
            pf_vld_reg    <= '0;
            at_vld_reg    <= '0;
            wp_reg        <= '0;
            cnt_reg       <= '0;
            confirmed_reg <= 1'b0;
            is_new_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.push && wp_open) begin
                fb_vld_reg[wp_reg[IDX_W-1:0]] <= 1'b1;
                wp_reg <= wp_reg + CNT_W'(1);
            end
            if (cmd.wp_clr) begin
                wp_reg <= '0;
            end
            if (cmd.cmp_en) begin
                pf_vld_reg[addr_q_reg] <= 1'b1;
            end
            if (cmd.at_clr) begin
                at_vld_reg <= '0;
            end else if (cmd.emit_ld) begin
                at_vld_reg[addr_q_reg] <= 1'b1;
            end
            if (cmd.cnt_clr) begin
                cnt_reg <= '0;
            end else if (cmd.cnt_inc && cnt_reg != LAST_IDX) begin
                cnt_reg <= cnt_reg + IDX_W'(1);
            end
            if (cmd.flags_init) begin
                confirmed_reg <= 1'b1;
                is_new_reg    <= 1'b0;
            end else if (cmd.cmp_en) begin
                confirmed_reg <= confirmed_reg && (fb_rd_reg == pf_rd_reg);
                is_new_reg    <= is_new_reg || (fb_rd_reg != at_rd_reg);
            end
            if (cmd.emit_ld || cmd.nodet_ld) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit_ld) begin
            out_det_reg  <= 1'b1;
            out_byte_reg <= fb_rd_reg;
            out_idx_reg  <= idx_wide[3:0];
            out_last_reg <= (addr_q_reg == LAST_IDX);
        end else if (cmd.nodet_ld) begin
            out_det_reg  <= 1'b0;
            out_byte_reg <= 8'd0;
            out_idx_reg  <= 4'd0;
            out_last_reg <= 1'b1;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_idx_reg, out_byte_reg};
    assign m_tuser  = out_det_reg;
    assign m_tlast  = out_last_reg;

    assign stat.kind      = kind;
    assign stat.rd_last   = (addr_q_reg == LAST_IDX);
    assign stat.confirmed = confirmed_reg;
    assign stat.is_new    = is_new_reg;
    assign stat.out_free  = out_free;

    a_wp_range: assert property (@(posedge aclk) disable iff (!aresetn)
        wp_reg <= FULL_POS)
        else $error("write position past buffer size");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit_ld || cmd.nodet_ld) |-> (!out_valid_reg || m_tready))
        else $error("output register overwritten while held");

    a_nodet_form: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.nodet_ld |=> (m_tvalid && m_tlast && !m_tuser && m_tdata == 16'd0))
        else $error("not-detected result malformed");

endmodule

>>> rtl/rfcd_ctrl.sv
module rfcd_ctrl
    import rfcd_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRIME,
        ST_CMP,
        ST_DECIDE,
        ST_NODET,
        ST_EMIT_RD,
        ST_EMIT_LD
    } state_t;

    state_t state_reg, state_next;
    logic   ready_reg;
    logic   accept;

    assign s_tready = ready_reg;
    assign accept   = s_tvalid && ready_reg;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (stat.kind)
                        KIND_DATA:  cmd.push   = 1'b1;
                        KIND_CLEAR: cmd.at_clr = 1'b1;
                        KIND_END: begin
                            cmd.wp_clr     = 1'b1;
                            cmd.cnt_clr    = 1'b1;
                            cmd.flags_init = 1'b1;
                            state_next     = ST_PRIME;
                        end
                        default: ;
                    endcase
                end
            end
            ST_PRIME: begin
                cmd.rd_en   = 1'b1;
                cmd.cnt_inc = 1'b1;
                state_next  = ST_CMP;
            end
            ST_CMP: begin
                cmd.rd_en   = 1'b1;
                cmd.cnt_inc = 1'b1;
                cmd.cmp_en  = 1'b1;
                if (stat.rd_last) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (stat.confirmed && stat.is_new) begin
                    cmd.cnt_clr = 1'b1;
                    state_next  = ST_EMIT_RD;
                end else begin
                    state_next = ST_NODET;
                end
            end
            ST_NODET: begin
                if (stat.out_free) begin
                    cmd.nodet_ld = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_EMIT_RD: begin
                cmd.rd_en  = 1'b1;
                state_next = ST_EMIT_LD;
            end
            ST_EMIT_LD: begin
                if (stat.out_free) begin
                    cmd.emit_ld = 1'b1;
                    if (stat.rd_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        cmd.cnt_inc = 1'b1;
                        state_next  = ST_EMIT_RD;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            ready_reg <= (state_next == ST_IDLE);
        end
    end

endmodule

>>> rtl/rfid_frame_confirm_dedup_core.sv
// Serial RFID frame confirmer with duplicate suppression. Reader bytes enter one
// item per cycle on the s_ side while the core is idle (s_tuser high = forget the
// accepted tag). Data bytes and start markers leave s_tready high. An end marker
// starts a scan over the TAG_BYTES-entry frame store, which compares it against the
// previous frame and the accepted tag and then gives either one not-detected result
// or TAG_BYTES tag bytes, each read from the stores and then loaded into the output
// register. The next item is accepted once the last result has been loaded into
// the output register. The output register lets the last result wait while new
// items enter.
// All stores read as zero after reset; no clearing pass is needed.
module rfid_frame_confirm_dedup_core
    import rfcd_pkg::*;
#(
    parameter int TAG_BYTES = TAG_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] tag_byte, [11:8] byte_index, [15:12] zero
    output logic        m_tuser,   // [0] detected
    output logic        m_tlast
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    rfcd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    rfcd_dp #(
        .TAG_BYTES (TAG_BYTES)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .cmd      (cmd),
        .stat     (stat)
    );

endmodule
